>>> rtl/rcos_pkg.sv
package rcos_pkg;

  localparam logic [1:0] ACT_LETTER = 2'd0;
  localparam logic [1:0] ACT_DISTANCE = 2'd1;
  localparam logic [1:0] ACT_TICK = 2'd2;

  localparam logic [2:0] MOT_STOP = 3'd0;
  localparam logic [2:0] MOT_FWD = 3'd1;
  localparam logic [2:0] MOT_BACK = 3'd2;
  localparam logic [2:0] MOT_LEFT = 3'd3;
  localparam logic [2:0] MOT_RIGHT = 3'd4;

  localparam logic [1:0] SRV_RIGHT = 2'd0;
  localparam logic [1:0] SRV_CENTRE = 2'd1;
  localparam logic [1:0] SRV_LEFT = 2'd2;

  localparam logic [3:0] PH_MANUAL = 4'd0;
  localparam logic [3:0] PH_FORWARD = 4'd1;
  localparam logic [3:0] PH_SETTLE_R1 = 4'd2;
  localparam logic [3:0] PH_MEASURE_R = 4'd3;
  localparam logic [3:0] PH_SETTLE_R2 = 4'd4;
  localparam logic [3:0] PH_SETTLE_L1 = 4'd5;
  localparam logic [3:0] PH_MEASURE_L = 4'd6;
  localparam logic [3:0] PH_SETTLE_GO_L = 4'd7;
  localparam logic [3:0] PH_SETTLE_GO_R = 4'd8;
  localparam logic [3:0] PH_TURN = 4'd9;

  localparam logic [7:0] LETTER_M = 8'h4D;
  localparam logic [7:0] LETTER_A = 8'h41;
  localparam logic [7:0] LETTER_S = 8'h53;
  localparam logic [7:0] LETTER_U = 8'h55;
  localparam logic [7:0] LETTER_D = 8'h44;
  localparam logic [7:0] LETTER_L = 8'h4C;
  localparam logic [7:0] LETTER_R = 8'h52;

  localparam logic [2:0] REG_OBSTACLE_LIMIT = 3'd0;
  localparam logic [2:0] REG_SETTLE_TICKS = 3'd1;
  localparam logic [2:0] REG_TURN_TICKS = 3'd2;
  localparam logic [2:0] REG_CRUISE_SPEED = 3'd3;
  localparam logic [2:0] REG_TURN_SPEED = 3'd4;

  localparam logic [6:0] SPEED_MAX = 7'd100;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] letter;
    logic [8:0] distance;
  } cmd_t;

  typedef struct packed {
    logic [2:0] motor_command;
    logic [6:0] motor_speed;
    logic [1:0] servo_position;
    logic       measure_request;
    logic       auto_active;
  } status_t;

  typedef struct packed {
    logic [8:0]  obstacle_limit;
    logic [15:0] settle_ticks;
    logic [15:0] turn_ticks;
    logic [6:0]  cruise_speed;
    logic [6:0]  turn_speed;
  } cfg_t;

endpackage

>>> rtl/rover_command_and_obstacle_sequencer.sv
// Each status item is registered into the output register, or the skid entry if blocked.
// Throughput: one item per cycle unless stalled; the state update is one combinational pass.
// A two-entry output buffer lets an item be accepted while one status item waits.
// Reset (synchronous, active high) clears the mode and sequence state, empties the
// output buffer and loads the register defaults 10, 750, 700, 100 and 50.
module rover_command_and_obstacle_sequencer #(
  parameter int TICK_COUNTER_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_stall,
  input  rcos_pkg::cmd_t    cmd_item,
  output logic              status_valid,
  input  logic              status_stall,
  output rcos_pkg::status_t status_item,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [15:0]       cfg_data
);

  rcos_pkg::cfg_t    cfg;
  rcos_pkg::status_t next_status;
  rcos_pkg::status_t skid_item;
  logic              skid_valid;
  logic              accept;
  logic              take;

  assign cmd_stall = skid_valid;
  assign accept = cmd_valid && !cmd_stall;
  assign take = status_valid && !status_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.obstacle_limit <= 9'd10;
      cfg.settle_ticks <= 16'd750;
      cfg.turn_ticks <= 16'd700;
      cfg.cruise_speed <= 7'd100;
      cfg.turn_speed <= 7'd50;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rcos_pkg::REG_OBSTACLE_LIMIT: cfg.obstacle_limit <= cfg_data[8:0];
        rcos_pkg::REG_SETTLE_TICKS: cfg.settle_ticks <= cfg_data;
        rcos_pkg::REG_TURN_TICKS: cfg.turn_ticks <= cfg_data;
        rcos_pkg::REG_CRUISE_SPEED: begin
          cfg.cruise_speed <= (cfg_data[6:0] > rcos_pkg::SPEED_MAX) ? rcos_pkg::SPEED_MAX
                                                                    : cfg_data[6:0];
        end
        rcos_pkg::REG_TURN_SPEED: begin
          cfg.turn_speed <= (cfg_data[6:0] > rcos_pkg::SPEED_MAX) ? rcos_pkg::SPEED_MAX
                                                                  : cfg_data[6:0];
        end
        default: cfg <= cfg;
      endcase
    end
  end

  rcos_core #(
    .TICK_COUNTER_BITS(TICK_COUNTER_BITS)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .en     (accept),
    .cfg    (cfg),
    .item   (cmd_item),
    .status (next_status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      status_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (skid_valid) begin
        if (take) begin
          status_valid <= 1'b1;
          skid_valid <= 1'b0;
        end
      end else if (accept) begin
        if (!status_valid || take) begin
          status_valid <= 1'b1;
        end else begin
          skid_valid <= 1'b1;
        end
      end else if (take) begin
        status_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (take) begin
        status_item <= skid_item;
      end
    end else if (accept) begin
      if (!status_valid || take) begin
        status_item <= next_status;
      end else begin
        skid_item <= next_status;
      end
    end
  end

  a_skid_behind_output: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> status_valid)
    else $error("skid entry held while output register empty");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    cmd_stall |-> (status_valid && $past(status_stall)))
    else $error("command channel stalled without a blocked status item");

  a_reset_empties: assert property (@(posedge clk)
    rst |=> (!status_valid && !skid_valid))
    else $error("output buffer not empty after reset");

  a_measure_motor: assert property (@(posedge clk) disable iff (rst)
    (status_valid && status_item.measure_request) |->
      (status_item.motor_command == rcos_pkg::MOT_FWD ||
       status_item.motor_command == rcos_pkg::MOT_STOP))
    else $error("motor turning or reversing while a reading is awaited");

endmodule

>>> rtl/rcos_core.sv
module rcos_core #(
  parameter int TICK_COUNTER_BITS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  rcos_pkg::cfg_t   cfg,
  input  rcos_pkg::cmd_t   item,
  output rcos_pkg::status_t status
);

  logic                         auto_selected, auto_selected_next;
  logic [2:0]                   manual_direction, manual_direction_next;
  logic [3:0]                   phase, phase_next;
  logic [TICK_COUNTER_BITS-1:0] wait_counter, wait_counter_next;
  logic [8:0]                   right_reading, right_reading_next;
  logic [2:0]                   motor, motor_next;
  logic [6:0]                   speed, speed_next;
  logic [1:0]                   servo, servo_next;
  logic [2:0]                   dir;
  logic                         in_wait;

  logic [TICK_COUNTER_BITS-1:0] settle_load, turn_load;

  assign settle_load = TICK_COUNTER_BITS'(cfg.settle_ticks);
  assign turn_load = TICK_COUNTER_BITS'(cfg.turn_ticks);

  assign in_wait = (phase == rcos_pkg::PH_SETTLE_R1) || (phase == rcos_pkg::PH_SETTLE_R2) ||
                   (phase == rcos_pkg::PH_SETTLE_L1) || (phase == rcos_pkg::PH_SETTLE_GO_L) ||
                   (phase == rcos_pkg::PH_SETTLE_GO_R) || (phase == rcos_pkg::PH_TURN);

  always_comb begin
    auto_selected_next = auto_selected;
    manual_direction_next = manual_direction;
    phase_next = phase;
    wait_counter_next = wait_counter;
    right_reading_next = right_reading;
    motor_next = motor;
    speed_next = speed;
    servo_next = servo;
    dir = manual_direction;
    unique case (item.action)
      rcos_pkg::ACT_LETTER: begin
        if (phase == rcos_pkg::PH_MANUAL) begin
          case (item.letter) inside
            rcos_pkg::LETTER_M, rcos_pkg::LETTER_A, rcos_pkg::LETTER_S: begin
              dir = rcos_pkg::MOT_STOP;
            end
            rcos_pkg::LETTER_U: dir = rcos_pkg::MOT_FWD;
            rcos_pkg::LETTER_D: dir = rcos_pkg::MOT_BACK;
            rcos_pkg::LETTER_L: dir = rcos_pkg::MOT_LEFT;
            rcos_pkg::LETTER_R: dir = rcos_pkg::MOT_RIGHT;
            default: dir = manual_direction;
          endcase
          manual_direction_next = dir;
          if (item.letter == rcos_pkg::LETTER_A) begin
            auto_selected_next = 1'b1;
            speed_next = cfg.cruise_speed;
            motor_next = rcos_pkg::MOT_FWD;
            phase_next = rcos_pkg::PH_FORWARD;
          end else begin
            case (dir) inside
              rcos_pkg::MOT_FWD, rcos_pkg::MOT_BACK: begin
                speed_next = cfg.cruise_speed;
                motor_next = dir;
              end
              rcos_pkg::MOT_LEFT, rcos_pkg::MOT_RIGHT: begin
                speed_next = cfg.turn_speed;
                motor_next = dir;
              end
              default: motor_next = rcos_pkg::MOT_STOP;
            endcase
          end
        end else if (phase == rcos_pkg::PH_FORWARD) begin
          if (item.letter == rcos_pkg::LETTER_M) begin
            auto_selected_next = 1'b0;
            motor_next = rcos_pkg::MOT_STOP;
            phase_next = rcos_pkg::PH_MANUAL;
          end
        end else begin
          if (item.letter == rcos_pkg::LETTER_M) begin
            auto_selected_next = 1'b0;
          end else if (item.letter == rcos_pkg::LETTER_A) begin
            auto_selected_next = 1'b1;
          end
        end
      end
      rcos_pkg::ACT_DISTANCE: begin
        if (phase == rcos_pkg::PH_FORWARD) begin
          if (item.distance < cfg.obstacle_limit) begin
            motor_next = rcos_pkg::MOT_STOP;
            servo_next = rcos_pkg::SRV_RIGHT;
            phase_next = rcos_pkg::PH_SETTLE_R1;
            wait_counter_next = settle_load;
          end
        end else if (phase == rcos_pkg::PH_MEASURE_R) begin
          right_reading_next = item.distance;
          phase_next = rcos_pkg::PH_SETTLE_R2;
          wait_counter_next = settle_load;
        end else if (phase == rcos_pkg::PH_MEASURE_L) begin
          phase_next = (item.distance >= right_reading) ? rcos_pkg::PH_SETTLE_GO_L
                                                        : rcos_pkg::PH_SETTLE_GO_R;
          wait_counter_next = settle_load;
        end
      end
      rcos_pkg::ACT_TICK: begin
        if (in_wait) begin
          if (wait_counter <= TICK_COUNTER_BITS'(1)) begin
            wait_counter_next = '0;
            case (phase) inside
              rcos_pkg::PH_SETTLE_R1: phase_next = rcos_pkg::PH_MEASURE_R;
              rcos_pkg::PH_SETTLE_R2: begin
                servo_next = rcos_pkg::SRV_LEFT;
                phase_next = rcos_pkg::PH_SETTLE_L1;
                wait_counter_next = settle_load;
              end
              rcos_pkg::PH_SETTLE_L1: phase_next = rcos_pkg::PH_MEASURE_L;
              rcos_pkg::PH_SETTLE_GO_L, rcos_pkg::PH_SETTLE_GO_R: begin
                servo_next = rcos_pkg::SRV_CENTRE;
                motor_next = (phase == rcos_pkg::PH_SETTLE_GO_L) ? rcos_pkg::MOT_LEFT
                                                                : rcos_pkg::MOT_RIGHT;
                phase_next = rcos_pkg::PH_TURN;
                wait_counter_next = turn_load;
              end
              rcos_pkg::PH_TURN: begin
                if (auto_selected) begin
                  motor_next = rcos_pkg::MOT_FWD;
                  phase_next = rcos_pkg::PH_FORWARD;
                end else begin
                  motor_next = rcos_pkg::MOT_STOP;
                  phase_next = rcos_pkg::PH_MANUAL;
                end
              end
              default: phase_next = phase;
            endcase
          end else begin
            wait_counter_next = wait_counter - TICK_COUNTER_BITS'(1);
          end
        end
      end
      default: phase_next = phase;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      auto_selected <= 1'b0;
      manual_direction <= rcos_pkg::MOT_STOP;
      phase <= rcos_pkg::PH_MANUAL;
      wait_counter <= '0;
      right_reading <= '0;
      motor <= rcos_pkg::MOT_STOP;
      speed <= '0;
      servo <= rcos_pkg::SRV_CENTRE;
    end else if (en) begin
      auto_selected <= auto_selected_next;
      manual_direction <= manual_direction_next;
      phase <= phase_next;
      wait_counter <= wait_counter_next;
      right_reading <= right_reading_next;
      motor <= motor_next;
      speed <= speed_next;
      servo <= servo_next;
    end
  end

  always_comb begin
    status.motor_command = motor_next;
    status.motor_speed = speed_next;
    status.servo_position = servo_next;
    status.measure_request = (phase_next == rcos_pkg::PH_FORWARD) ||
                             (phase_next == rcos_pkg::PH_MEASURE_R) ||
                             (phase_next == rcos_pkg::PH_MEASURE_L);
    status.auto_active = auto_selected_next;
  end

endmodule
